// ===== design/dghp_pkg.sv =====
package dghp_pkg;

	localparam int ERR_W   = 10;
	localparam int DUTY_W  = 11;
	localparam int FRAC_W  = 8;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int PGAIN_W = 10;
	localparam int IGAIN_W = 16;
	localparam int DGAIN_W = 10;
	localparam int GINT_W  = 18;
	localparam int FINT_W  = 19;

	localparam int GENTLE_LIMIT = 400;
	localparam int FAST_LIMIT   = 1000;
	localparam int GENTLE_ILIM  = GENTLE_LIMIT * (1 << FRAC_W);
	localparam int FAST_ILIM    = FAST_LIMIT * (1 << FRAC_W);

	localparam logic [IDX_W-1:0] REG_GENTLE_P = 3'd0;
	localparam logic [IDX_W-1:0] REG_GENTLE_I = 3'd1;
	localparam logic [IDX_W-1:0] REG_GENTLE_D = 3'd2;
	localparam logic [IDX_W-1:0] REG_FAST_P   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FAST_I   = 3'd4;
	localparam logic [IDX_W-1:0] REG_FAST_D   = 3'd5;
	localparam logic [IDX_W-1:0] REG_HOLD     = 3'd6;

	localparam logic [PGAIN_W-1:0] GENTLE_P_RST = 10'd30;
	localparam logic [IGAIN_W-1:0] GENTLE_I_RST = 16'd0;
	localparam logic [DGAIN_W-1:0] GENTLE_D_RST = 10'd10;
	localparam logic [PGAIN_W-1:0] FAST_P_RST   = 10'd50;
	localparam logic [IGAIN_W-1:0] FAST_I_RST   = 16'd0;
	localparam logic [DGAIN_W-1:0] FAST_D_RST   = 10'd50;

	typedef struct packed {
		logic [PGAIN_W-1:0] gentle_p_gain;
		logic [IGAIN_W-1:0] gentle_i_gain;
		logic [DGAIN_W-1:0] gentle_d_gain;
		logic [PGAIN_W-1:0] fast_p_gain;
		logic [IGAIN_W-1:0] fast_i_gain;
		logic [DGAIN_W-1:0] fast_d_gain;
		logic               hold_loop;
	} cfg_t;

endpackage

// ===== design/dghp_if.sv =====
interface dghp_req_if
	import dghp_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic signed [ERR_W-1:0]  angle_error;

	modport source (output valid, output cmd, output angle_error, input ready);
	modport sink (input valid, input cmd, input angle_error, output ready);
endinterface

interface dghp_rsp_if
	import dghp_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [DUTY_W-1:0] steer_duty;

	modport source (output valid, output steer_duty, input ready);
	modport sink (input valid, input steer_duty, output ready);
endinterface

// ===== design/dghp_cfg.sv =====
module dghp_cfg
	import dghp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gentle_p_gain <= GENTLE_P_RST;
			cfg_q.gentle_i_gain <= GENTLE_I_RST;
			cfg_q.gentle_d_gain <= GENTLE_D_RST;
			cfg_q.fast_p_gain   <= FAST_P_RST;
			cfg_q.fast_i_gain   <= FAST_I_RST;
			cfg_q.fast_d_gain   <= FAST_D_RST;
			cfg_q.hold_loop     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GENTLE_P: cfg_q.gentle_p_gain <= cfg_wdata[PGAIN_W-1:0];
				REG_GENTLE_I: cfg_q.gentle_i_gain <= cfg_wdata[IGAIN_W-1:0];
				REG_GENTLE_D: cfg_q.gentle_d_gain <= cfg_wdata[DGAIN_W-1:0];
				REG_FAST_P:   cfg_q.fast_p_gain   <= cfg_wdata[PGAIN_W-1:0];
				REG_FAST_I:   cfg_q.fast_i_gain   <= cfg_wdata[IGAIN_W-1:0];
				REG_FAST_D:   cfg_q.fast_d_gain   <= cfg_wdata[DGAIN_W-1:0];
				REG_HOLD:     cfg_q.hold_loop     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/dghp_datapath.sv =====
module dghp_datapath
	import dghp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     commit,
	input  logic                     cmd,
	input  logic signed [ERR_W-1:0]  angle_error,
	input  cfg_t                     cfg,
	output logic signed [DUTY_W-1:0] duty
);

	localparam int ACC_W  = 27;
	localparam int PD_W   = 22;
	localparam int SUM_W  = 32;
	localparam int DINT_W = SUM_W - FRAC_W;

	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [GINT_W-1:0] gentle_int_q;
	logic signed [FINT_W-1:0] fast_int_q;
	logic signed [DUTY_W-1:0] held_duty_q;

	logic signed [PD_W-1:0]   err_x;
	logic signed [PD_W-1:0]   deriv_x;
	logic signed [PD_W-1:0]   kp_x;
	logic signed [PD_W-1:0]   kd_x;
	logic signed [PD_W-1:0]   pd;
	logic signed [ACC_W-1:0]  ki_x;
	logic signed [ACC_W-1:0]  err_a;
	logic signed [ACC_W-1:0]  ki_prod;
	logic signed [ACC_W-1:0]  acc_old;
	logic signed [ACC_W-1:0]  acc_new;
	logic signed [ACC_W-1:0]  acc_lim;
	logic signed [ACC_W-1:0]  acc_clamped;
	logic signed [SUM_W-1:0]  sum;
	logic signed [DINT_W-1:0] sum_int;
	logic signed [DINT_W-1:0] duty_raw;
	logic signed [DINT_W-1:0] duty_lim;
	logic signed [DINT_W-1:0] duty_clamped;

	always_comb begin
		err_x   = PD_W'(angle_error);
		deriv_x = PD_W'(angle_error) - PD_W'(prev_err_q);
		err_a   = ACC_W'(angle_error);
		if (cmd) begin
			kp_x     = PD_W'({1'b0, cfg.fast_p_gain});
			kd_x     = PD_W'({1'b0, cfg.fast_d_gain});
			ki_x     = ACC_W'({1'b0, cfg.fast_i_gain});
			acc_old  = ACC_W'(fast_int_q);
			acc_lim  = ACC_W'(FAST_ILIM);
			duty_lim = DINT_W'(FAST_LIMIT);
		end else begin
			kp_x     = PD_W'({1'b0, cfg.gentle_p_gain});
			kd_x     = PD_W'({1'b0, cfg.gentle_d_gain});
			ki_x     = ACC_W'({1'b0, cfg.gentle_i_gain});
			acc_old  = ACC_W'(gentle_int_q);
			acc_lim  = ACC_W'(GENTLE_ILIM);
			duty_lim = DINT_W'(GENTLE_LIMIT);
		end

		ki_prod = ki_x * err_a;
		pd      = kp_x * err_x + kd_x * deriv_x;
		acc_new = cfg.hold_loop ? acc_old : acc_old + ki_prod;
		sum     = (SUM_W'(pd) <<< FRAC_W) + SUM_W'(acc_new);

		// truncate toward zero
		sum_int = sum[SUM_W-1:FRAC_W];
		if (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0))
			sum_int = sum_int + DINT_W'(1);

		duty_raw = cfg.hold_loop ? DINT_W'(held_duty_q) : sum_int;

		if (duty_raw > duty_lim)
			duty_clamped = duty_lim;
		else if (duty_raw < -duty_lim)
			duty_clamped = -duty_lim;
		else
			duty_clamped = duty_raw;

		if (acc_new > acc_lim)
			acc_clamped = acc_lim;
		else if (acc_new < -acc_lim)
			acc_clamped = -acc_lim;
		else
			acc_clamped = acc_new;

		duty = duty_clamped[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			gentle_int_q <= '0;
			fast_int_q   <= '0;
			held_duty_q  <= '0;
		end else if (commit) begin
			prev_err_q  <= angle_error;
			held_duty_q <= duty_clamped[DUTY_W-1:0];
			if (cmd)
				fast_int_q <= acc_clamped[FINT_W-1:0];
			else
				gentle_int_q <= acc_clamped[GINT_W-1:0];
		end
	end

endmodule

// ===== design/dual_gain_heading_pid_unit.sv =====
// Dual-gain heading PID. Each req transaction carries a heading error and a
// gain-set select (gentle, limit +-400, or fast, limit +-1000); each one gives
// exactly one rsp transaction with the saturated steering duty. The unit
// takes one transaction per clock unless req.ready is low: the sample lands
// in an input register, the PID sum, truncation, clamps and state update are
// computed combinationally from it, and the duty is held in a result
// register. The integrators, previous error and last duty are updated when
// the sample moves into the result register, and the next sample reads them.
// req.ready drops only while the result register is full and rsp.ready is
// low. Gains and hold must be written through cfg_we/cfg_index/cfg_wdata
// only while no transaction is in flight; the unit does not enforce this.
module dual_gain_heading_pid_unit
	import dghp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	dghp_req_if.sink         req,
	dghp_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t                     cfg;
	logic                     valid_s1;
	logic                     cmd_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic                     out_valid_q;
	logic signed [DUTY_W-1:0] duty_q;
	logic signed [DUTY_W-1:0] duty;
	logic                     advance;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	dghp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dghp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (advance),
		.cmd         (cmd_s1),
		.angle_error (err_s1),
		.cfg         (cfg),
		.duty        (duty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= req.cmd;
			err_s1 <= req.angle_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_q <= duty;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.steer_duty = duty_q;

endmodule
